[hw/rtl/fifo_replacement_id_cache_defines.svh]
// Assertion macros for the id cache RTL.
// Needs nothing else; included by files that carry assertions.
`ifndef FIFO_REPLACEMENT_ID_CACHE_DEFINES_SVH
`define FIFO_REPLACEMENT_ID_CACHE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FRC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define FRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/frc_pkg.sv]
// Shared constants, codes and types of the FIFO-replacement id cache.
// No dependencies; imported by every RTL module of the block.
package frc_pkg;

    localparam int FRC_DEPTH   = 16;
    localparam int FRC_ID_BITS = 32;
    localparam int CAP_W       = 5;   // capacity register width
    localparam int OCC_W       = 5;   // occupancy field width

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic CMD_PUSH  = 1'b0;
    localparam logic CMD_LIST  = 1'b1;
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_LIST = 1'b1;

    // Per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic insert;  // write key into first free slot
        logic evict;   // shift toward oldest, key into newest slot
    } frc_ctl_t;

endpackage

[hw/rtl/fifo_replacement_id_cache.sv]
// Top level of the FIFO-replacement id cache: control, fill count, result register.
// Depends on frc_pkg, frc_chain (frc_cell) and fifo_replacement_id_cache_defines.svh.
//
// Channel  Dir  Handshake             Payload
// in       in   in_valid / in_ready   command, ident
// out      out  out_valid / out_ready kind, was_present, dropped_valid, dropped_ident,
//                                     list_valid, list_ident, occupancy, last
// cfg      in   cfg_wr_en             cfg_wr_data (capacity)
//
// On a push all cells compare the id at once and the row shifts or fills at the
// accept edge, so pushes can arrive back to back while out drains.
// An empty list loads its one result at the accept edge. A non-empty list loads
// nothing at the accept edge, then one result per stored id (newest first) from a
// down-counting slot index, so it holds in_ready low until the walk reaches slot 0.
// in_ready is low while a list is being walked or the result register is full
// and not being taken. Reset empties the row and sets capacity to 16.
`include "fifo_replacement_id_cache_defines.svh"

module fifo_replacement_id_cache
    import frc_pkg::*;
#(
    parameter int DEPTH   = FRC_DEPTH,
    parameter int ID_BITS = FRC_ID_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration
    input  logic               cfg_wr_en,
    input  logic [CAP_W-1:0]   cfg_wr_data,
    // input items
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               command,
    input  logic [ID_BITS-1:0] ident,
    // result items
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic               was_present,
    output logic               dropped_valid,
    output logic [ID_BITS-1:0] dropped_ident,
    output logic               list_valid,
    output logic [ID_BITS-1:0] list_ident,
    output logic [OCC_W-1:0]   occupancy,
    output logic               last
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic               state_reg;
    logic               state_next;
    logic [CNT_W-1:0]   fill_count_reg;
    logic [CNT_W-1:0]   fill_count_next;
    logic [IDX_W-1:0]   list_idx_reg;
    logic [IDX_W-1:0]   list_idx_next;
    logic [CAP_W-1:0]   capacity_reg;

    // result register
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               kind_reg;
    logic               was_present_reg;
    logic               dropped_valid_reg;
    logic [ID_BITS-1:0] dropped_ident_reg;
    logic               list_valid_reg;
    logic [ID_BITS-1:0] list_ident_reg;
    logic [OCC_W-1:0]   occupancy_reg;
    logic               last_reg;

    logic               out_free;
    logic               in_acc;
    logic               push_acc;
    logic               list_acc;
    logic               list_step;
    logic               hit;
    logic               full;
    logic [31:0]        eff_cap;
    logic [ID_BITS-1:0] head_id;
    logic [ID_BITS-1:0] read_id;
    logic [DEPTH-1:0]   valid_vec;
    frc_ctl_t           ctl;
    logic               list_acc_empty_ok;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE) && out_free;
    assign in_acc    = in_valid && in_ready;
    assign push_acc  = in_acc && (command == CMD_PUSH);
    assign list_acc  = in_acc && (command == CMD_LIST);
    assign list_step = (state_reg == ST_LIST) && out_free;

    // capacity 0 acts as 1, values above DEPTH act as DEPTH
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            eff_cap = 32'd1;
        end
        else if (32'(capacity_reg) > 32'(DEPTH))
        begin
            eff_cap = 32'(DEPTH);
        end
        else
        begin
            eff_cap = 32'(capacity_reg);
        end
    end

    assign full = (32'(fill_count_reg) >= eff_cap) && (fill_count_reg != '0);

    assign ctl.evict  = push_acc && !hit && full;
    assign ctl.insert = push_acc && !hit && !full;

    frc_chain #(
        .DEPTH   (DEPTH),
        .ID_BITS (ID_BITS),
        .IDX_W   (IDX_W)
    ) u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .key       (ident),
        .read_idx  (list_idx_reg),
        .hit       (hit),
        .head_id   (head_id),
        .read_id   (read_id),
        .valid_vec (valid_vec)
    );

    always_comb
    begin
        state_next      = state_reg;
        list_idx_next   = list_idx_reg;
        fill_count_next = fill_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;

        if (ctl.insert)
        begin
            fill_count_next = fill_count_reg + 1'b1;
        end

        // a non-empty list gets its results from the walk only
        if (push_acc || (list_acc && (fill_count_reg == '0)) || list_step)
        begin
            out_valid_next = 1'b1;
        end

        // non-empty list: walk slots from newest down to slot 0
        if (list_acc && (fill_count_reg != '0))
        begin
            state_next    = ST_LIST;
            list_idx_next = IDX_W'(fill_count_reg - 1'b1);
        end

        if (list_step)
        begin
            if (list_idx_reg == '0)
            begin
                state_next = ST_IDLE;
            end
            else
            begin
                list_idx_next = list_idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            fill_count_reg <= '0;
            list_idx_reg   <= '0;
            capacity_reg   <= CAP_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            list_idx_reg   <= list_idx_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr_en)
            begin
                capacity_reg <= cfg_wr_data;
            end
        end
    end

    // result payload; fields not used by a kind are zero
    always_ff @(posedge clk)
    begin
        if (push_acc)
        begin
            kind_reg          <= KIND_PUSH;
            was_present_reg   <= hit;
            dropped_valid_reg <= ctl.evict;
            dropped_ident_reg <= ctl.evict ? head_id : '0;
            list_valid_reg    <= 1'b0;
            list_ident_reg    <= '0;
            occupancy_reg     <= OCC_W'(fill_count_next);
            last_reg          <= 1'b1;
        end
        else if (list_acc && (fill_count_reg == '0))
        begin
            // only the empty store gets its result here
            kind_reg          <= KIND_LIST;
            was_present_reg   <= 1'b0;
            dropped_valid_reg <= 1'b0;
            dropped_ident_reg <= '0;
            list_valid_reg    <= 1'b0;
            list_ident_reg    <= '0;
            occupancy_reg     <= OCC_W'(fill_count_reg);
            last_reg          <= 1'b1;
        end
        else if (list_step)
        begin
            kind_reg          <= KIND_LIST;
            was_present_reg   <= 1'b0;
            dropped_valid_reg <= 1'b0;
            dropped_ident_reg <= '0;
            list_valid_reg    <= 1'b1;
            list_ident_reg    <= read_id;
            occupancy_reg     <= OCC_W'(fill_count_reg);
            last_reg          <= (list_idx_reg == '0);
        end
    end

    // a non-empty list loads the result register from the walk, not on accept
    assign list_acc_empty_ok = !list_acc || (fill_count_reg == '0) || (state_next == ST_LIST);

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign was_present   = was_present_reg;
    assign dropped_valid = dropped_valid_reg;
    assign dropped_ident = dropped_ident_reg;
    assign list_valid    = list_valid_reg;
    assign list_ident    = list_ident_reg;
    assign occupancy     = occupancy_reg;
    assign last          = last_reg;

    `FRC_ASSERT_NOW(a_valid_run, clk, rst_n, 1'b1,
        $countones(valid_vec) == int'(fill_count_reg), "valid bits disagree with fill count")
    `FRC_ASSERT_NOW(a_list_nonempty, clk, rst_n, state_reg == ST_LIST,
        fill_count_reg != '0, "list walk over an empty store")
    `FRC_ASSERT_NEXT(a_insert_grows, clk, rst_n, ctl.insert,
        fill_count_reg == $past(fill_count_reg) + 1'b1, "insert did not grow the store")
    `FRC_ASSERT_NEXT(a_hit_keeps, clk, rst_n, push_acc && hit,
        $stable(fill_count_reg) && $stable(valid_vec), "hit changed the store")
    `FRC_ASSERT_NOW(a_list_entry, clk, rst_n, list_acc,
        list_acc_empty_ok, "non-empty list did not start a walk")

endmodule

[hw/rtl/frc_cell.sv]
// One storage cell of the id row: an id, its valid bit and a comparator.
// Depends on frc_pkg.
module frc_cell
    import frc_pkg::*;
#(
    parameter int ID_BITS = FRC_ID_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  frc_ctl_t           ctl,
    input  logic [ID_BITS-1:0] key,
    input  logic               older_valid,
    input  logic               newer_valid,
    input  logic [ID_BITS-1:0] newer_id,
    output logic               valid,
    output logic [ID_BITS-1:0] id,
    output logic               match
);

    logic               valid_reg;
    logic               valid_next;
    logic [ID_BITS-1:0] id_reg;
    logic [ID_BITS-1:0] id_next;

    always_comb
    begin
        valid_next = valid_reg;
        id_next    = id_reg;
        // evict: take the newer neighbor, the newest valid cell takes the key
        if (ctl.evict && valid_reg)
        begin
            id_next = newer_valid ? newer_id : key;
        end
        // insert: first empty cell above the valid run takes the key
        if (ctl.insert && !valid_reg && older_valid)
        begin
            id_next    = key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg <= id_next;
    end

    assign valid = valid_reg;
    assign id    = id_reg;
    assign match = valid_reg && (id_reg == key);

endmodule

[hw/rtl/frc_chain.sv]
// Row of id cells, oldest at slot 0, with hit reduction and a read port.
// Depends on frc_pkg and frc_cell.
module frc_chain
    import frc_pkg::*;
#(
    parameter int DEPTH   = FRC_DEPTH,
    parameter int ID_BITS = FRC_ID_BITS,
    parameter int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  frc_ctl_t           ctl,
    input  logic [ID_BITS-1:0] key,
    input  logic [IDX_W-1:0]   read_idx,
    output logic               hit,
    output logic [ID_BITS-1:0] head_id,
    output logic [ID_BITS-1:0] read_id,
    output logic [DEPTH-1:0]   valid_vec
);

    logic [ID_BITS-1:0] ids [DEPTH];
    logic [DEPTH-1:0]   match_vec;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic               older_v;
        logic               newer_v;
        logic [ID_BITS-1:0] newer_d;

        if (i == 0)
        begin : g_first
            assign older_v = 1'b1;
        end
        else
        begin : g_mid_lo
            assign older_v = valid_vec[i-1];
        end

        if (i == DEPTH-1)
        begin : g_last
            assign newer_v = 1'b0;
            assign newer_d = key;
        end
        else
        begin : g_mid_hi
            assign newer_v = valid_vec[i+1];
            assign newer_d = ids[i+1];
        end

        frc_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .key         (key),
            .older_valid (older_v),
            .newer_valid (newer_v),
            .newer_id    (newer_d),
            .valid       (valid_vec[i]),
            .id          (ids[i]),
            .match       (match_vec[i])
        );
    end

    assign hit     = |match_vec;
    assign head_id = ids[0];
    assign read_id = ids[read_idx];

endmodule
